FILE: sv/dual_stack_with_transfer_macros.svh
// ----------------------------------------------------------------------------
// Dual stack with transfer: assertion macros
// Shared property forms for the checker of the dual stack block.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_WITH_TRANSFER_MACROS_SVH
`define DUAL_STACK_WITH_TRANSFER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSWT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dswt_pkg.sv
// ----------------------------------------------------------------------------
// Dual stack with transfer: package
// Command and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package dswt_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PORT_W         = 32;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_MOVE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESULT,
        S_MOVE
    } state_t;

endpackage

FILE: sv/dswt_ram.sv
// ----------------------------------------------------------------------------
// Dual stack with transfer: stack memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dswt_ram #(
    parameter int DEPTH      = dswt_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dswt_pkg::DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);
    import dswt_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read data holds until the next read, so it can wait for a slow consumer.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/dswt_ctrl.sv
// ----------------------------------------------------------------------------
// Dual stack with transfer: controller
// Stack counters, command sequencer, move copy loop and output register.
// ----------------------------------------------------------------------------
module dswt_ctrl #(
    parameter int DEPTH      = dswt_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dswt_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  logic [1:0]                            cmd,
    input  logic                                  stack_sel,
    input  logic signed [dswt_pkg::PORT_W-1:0]    push_value,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic signed [dswt_pkg::PORT_W-1:0]    pop_value,
    output logic [1:0]                            status,
    output logic [1:0]                            ram_we,
    output logic [1:0][$clog2(DEPTH)-1:0]         ram_waddr,
    output logic [1:0][DATA_WIDTH-1:0]            ram_wdata,
    output logic [1:0]                            ram_re,
    output logic [1:0][$clog2(DEPTH)-1:0]         ram_raddr,
    input  logic [1:0][DATA_WIDTH-1:0]            ram_rdata
);
    import dswt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_SUM = (CW + 1)'(DEPTH);

    state_t                state_reg, state_next;
    logic [1:0][CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;
    logic                  sel_reg, sel_next;
    status_t               res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PORT_W-1:0]     out_value_reg, out_value_next;
    status_t               out_status_reg, out_status_next;

    cmd_t                  cmd_in;
    logic                  accept;
    logic [CW-1:0]         dst_cnt;
    logic [CW-1:0]         dst_cnt_m1;
    logic [CW:0]           cnt_sum;
    logic                  full;
    logic                  empty;
    logic                  src_sel;
    logic [CW-1:0]         src_cnt;
    logic                  mv_more;
    logic [CW-1:0]         mv_pos;
    logic                  out_free;
    logic [DATA_WIDTH+PORT_W-1:0] push_ext;
    logic [DATA_WIDTH+PORT_W-1:0] pop_ext;

    assign cmd_in     = cmd_t'(cmd);
    assign accept     = cmd_valid && (state_reg == S_IDLE);
    assign dst_cnt    = cnt_reg[stack_sel];
    assign dst_cnt_m1 = dst_cnt - CW'(1);
    assign cnt_sum    = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
    assign full       = cnt_sum >= DEPTH_SUM;
    assign empty      = dst_cnt == '0;
    assign src_sel    = ~sel_reg;
    assign src_cnt    = cnt_reg[src_sel];
    assign mv_more    = idx_reg != src_cnt;
    assign mv_pos     = cnt_reg[sel_reg] + idx_reg;
    assign out_free   = !out_valid_reg || rsp_ready;
    assign push_ext   = {{DATA_WIDTH{1'b0}}, push_value};
    assign pop_ext    = {{PORT_W{1'b0}}, ram_rdata[sel_reg]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_in)
                        CMD_PUSH: if (full) state_next = S_RESULT;
                        CMD_POP:  state_next = S_RESULT;
                        CMD_MOVE: state_next = S_MOVE;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOVE:
            begin
                if (!mv_more)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls and counters
    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        sel_next        = sel_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        ram_we          = '0;
        ram_re          = '0;
        ram_waddr       = '0;
        ram_raddr       = '0;
        ram_wdata[0]    = push_ext[DATA_WIDTH-1:0];
        ram_wdata[1]    = push_ext[DATA_WIDTH-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_in)
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we[stack_sel]    = 1'b1;
                                ram_waddr[stack_sel] = dst_cnt[AW-1:0];
                                cnt_next[stack_sel]  = dst_cnt + CW'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            sel_next = stack_sel;
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                res_status_next      = ST_OK;
                                ram_re[stack_sel]    = 1'b1;
                                ram_raddr[stack_sel] = dst_cnt_m1[AW-1:0];
                                cnt_next[stack_sel]  = dst_cnt_m1;
                            end
                        end
                        CMD_MOVE:
                        begin
                            sel_next     = stack_sel;
                            idx_next     = '0;
                            wr_pend_next = 1'b0;
                        end
                        default:
                        begin
                            sel_next = sel_reg;
                        end
                    endcase
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = (res_status_reg == ST_OK) ? pop_ext[PORT_W-1:0] : '0;
                end
            end
            S_MOVE:
            begin
                // The word read from the source in the previous cycle lands on the destination.
                if (wr_pend_reg)
                begin
                    ram_we[sel_reg]    = 1'b1;
                    ram_waddr[sel_reg] = wr_addr_reg;
                    ram_wdata[sel_reg] = ram_rdata[src_sel];
                end
                if (mv_more)
                begin
                    ram_re[src_sel]    = 1'b1;
                    ram_raddr[src_sel] = idx_reg[AW-1:0];
                    idx_next           = idx_reg + CW'(1);
                    wr_pend_next       = 1'b1;
                    wr_addr_next       = mv_pos[AW-1:0];
                end
                else
                begin
                    wr_pend_next      = 1'b0;
                    cnt_next[sel_reg] = cnt_reg[sel_reg] + src_cnt;
                    cnt_next[src_sel] = '0;
                end
            end
            default:
            begin
                wr_pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wr_addr_reg    <= wr_addr_next;
        sel_reg        <= sel_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign cmd_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;
    assign pop_value = out_value_reg;
    assign status    = out_status_reg;

endmodule

FILE: sv/dual_stack_with_transfer.sv
// ----------------------------------------------------------------------------
// Dual stack with transfer: top level
// Two LIFO stacks sharing one capacity, with push, pop and whole-stack move.
// ----------------------------------------------------------------------------
// Each stack lives in its own single-port-read, single-port-write memory with
// a registered read. A successful push writes the memory in the cycle that
// accepts it. A pop, and a push that is refused because both stacks together
// hold DEPTH words, go through the result state, where the output register is
// loaded (for a pop, with the word that the memory read returned); they wait
// there only while the previous response word is still held. A move of n words
// has the accepting cycle, then one word per cycle through the source memory's
// read port, then a last step to write the last word and update the counts.
// Memories need no clearing after reset.
module dual_stack_with_transfer #(
    parameter int DEPTH      = dswt_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dswt_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  logic [1:0]                         cmd,
    input  logic                               stack_sel,
    input  logic signed [dswt_pkg::PORT_W-1:0] push_value,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [dswt_pkg::PORT_W-1:0] pop_value,
    output logic [1:0]                         status
);
    import dswt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [1:0]                 ram_we;
    logic [1:0][AW-1:0]         ram_waddr;
    logic [1:0][DATA_WIDTH-1:0] ram_wdata;
    logic [1:0]                 ram_re;
    logic [1:0][AW-1:0]         ram_raddr;
    logic [1:0][DATA_WIDTH-1:0] ram_rdata;

    dswt_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .stack_sel  (stack_sel),
        .push_value (push_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .pop_value  (pop_value),
        .status     (status),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Memory 0 holds stack A, memory 1 holds stack B.
    for (genvar g = 0; g < 2; g++)
    begin : g_stack
        dswt_ram #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata[g]),
            .re    (ram_re[g]),
            .raddr (ram_raddr[g]),
            .rdata (ram_rdata[g])
        );
    end

endmodule

FILE: sv/dswt_checker.sv
// ----------------------------------------------------------------------------
// Dual stack with transfer: port checker
// Checks on the top level's ports over time, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_stack_with_transfer_macros.svh"

module dswt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cmd_valid,
    input logic                               cmd_ready,
    input logic [1:0]                         cmd,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic signed [dswt_pkg::PORT_W-1:0] pop_value,
    input logic [1:0]                         status
);
    import dswt_pkg::*;

    // A response word that is not taken must stay as it is.
    `DSWT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(pop_value) && $stable(status), "response word changed while stalled")

    // Only a successful pop carries a value.
    `DSWT_ASSERT_IMPLY(a_zero_value, clk, rst_n, rsp_valid && (status != ST_OK), pop_value == '0, "non-zero value with a failure status")

    // A fresh response follows an accepted command through the result state and the output register.
    `DSWT_ASSERT_IMPLY(a_rsp_cause, clk, rst_n, $rose(rsp_valid), $past(cmd_valid && cmd_ready, 2), "response without an accepted command")

    // A pop always occupies the block for its memory read.
    `DSWT_ASSERT_NEXT(a_pop_busy, clk, rst_n, cmd_valid && cmd_ready && (cmd == CMD_POP), !cmd_ready, "ready high straight after a pop")

endmodule

bind dual_stack_with_transfer dswt_checker u_dswt_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual stack with transfer: testbench
// Sends push, pop, move and unused command words, directed first and then in random phases,
// and checks every response word against a predictor of both stacks.
// ----------------------------------------------------------------------------
module tb_top;
    import dswt_pkg::*;

    localparam int               DEPTH         = DEPTH_DEF;
    localparam int               CLK_PERIOD    = 10;
    localparam int               CYCLE_LIMIT   = 1_000_000;
    localparam int               ITEM_TARGET   = 860;
    localparam int               HOLD_CYCLES   = 400;
    localparam int               SETTLE_CYCLES = DEPTH + 40;
    localparam logic [1:0]       CMD_UNUSED    = 2'd3;
    localparam logic             SEL_A         = 1'b0;
    localparam logic             SEL_B         = 1'b1;
    localparam logic [PORT_W-1:0] MOST_NEG     = {1'b1, {(PORT_W - 1){1'b0}}};
    localparam logic [PORT_W-1:0] MOST_POS     = {1'b0, {(PORT_W - 1){1'b1}}};
    localparam logic [PORT_W-1:0] ALL_ONES     = '1;
    localparam logic [PORT_W-1:0] ALL_ZEROS    = '0;

    typedef struct packed {
        logic [PORT_W-1:0] value;
        status_t           status;
    } stack_reply_t;

    class stack_scoreboard;
        logic [PORT_W-1:0] words [2][DEPTH];
        int unsigned       depth_of [2];
        stack_reply_t      reply_q [$];
        int unsigned       errors;

        function new();
            depth_of[0] = 0;
            depth_of[1] = 0;
            errors      = 0;
        endfunction

        function int unsigned pending();
            return reply_q.size();
        endfunction

        function void note_command(logic [1:0] op, logic sel, logic [PORT_W-1:0] value);
            stack_reply_t reply;
            int unsigned  dst;
            int unsigned  src;
            int unsigned  i;
            dst = sel;
            src = !sel;
            case (op)
                CMD_PUSH:
                begin
                    // The two stacks share one capacity of DEPTH words.
                    if (depth_of[0] + depth_of[1] >= DEPTH)
                    begin
                        reply.value  = '0;
                        reply.status = ST_FULL;
                        reply_q.insert(reply_q.size(), reply);
                    end
                    else
                    begin
                        words[dst][depth_of[dst]] = value;
                        depth_of[dst]++;
                    end
                end
                CMD_POP:
                begin
                    if (depth_of[dst] == 0)
                    begin
                        reply.value  = '0;
                        reply.status = ST_EMPTY;
                    end
                    else
                    begin
                        depth_of[dst]--;
                        reply.value  = words[dst][depth_of[dst]];
                        reply.status = ST_OK;
                    end
                    reply_q.insert(reply_q.size(), reply);
                end
                CMD_MOVE:
                begin
                    // The source keeps its order: its bottom word lands just above
                    // the old top of the destination.
                    for (i = 0; i < depth_of[src]; i++)
                        words[dst][depth_of[dst] + i] = words[src][i];
                    depth_of[dst] += depth_of[src];
                    depth_of[src] = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [PORT_W-1:0] value, logic [1:0] st);
            stack_reply_t want;
            if (reply_q.size() == 0)
            begin
                $error("unexpected response word: pop_value %h, status %0d", value, st);
                errors++;
                return;
            end
            want = reply_q.pop_front();
            if (value !== want.value)
            begin
                $error("pop_value: expected %h, actual %h", want.value, value);
                errors++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cmd_valid;
    logic                     cmd_ready;
    logic [1:0]               cmd;
    logic                     stack_sel;
    logic signed [PORT_W-1:0] push_value;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic signed [PORT_W-1:0] pop_value;
    logic [1:0]               status;

    stack_scoreboard sb;
    int unsigned     real_items  = 0;
    int unsigned     cycle_count = 0;
    logic            calm        = 1'b0;
    logic            hold_req    = 1'b0;
    logic            hold_active = 1'b0;

    dual_stack_with_transfer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .stack_sel  (stack_sel),
        .push_value (push_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .pop_value  (pop_value),
        .status     (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(pop_value, status);
    end

    // Mostly short gaps, a few long ones, none at all in calm phases.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [PORT_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return ALL_ZEROS;
            3:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Called at a rising edge; returns at a rising edge with no pending
    // assignment, so valid can stay high straight into the next word.
    task automatic send_word(logic [1:0] op, logic sel, logic [PORT_W-1:0] value);
        int unsigned gap;
        cmd_valid  <= 1'b1;
        cmd        <= op;
        stack_sel  <= sel;
        push_value <= value;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.note_command(op, sel, value);
        if (op != CMD_UNUSED)
            real_items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Always moves on by at least one edge, so the caller may drive again at once.
    task automatic drain_wait();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic fill_stacks();
        int unsigned r;
        while (sb.depth_of[0] + sb.depth_of[1] < DEPTH)
        begin
            r = $urandom_range(0, 99);
            if (r < 92)
                send_word(CMD_PUSH, 1'($urandom), pick_value());
            else if (r < 97)
                send_word(CMD_MOVE, 1'($urandom), pick_value());
            else
                send_word(CMD_POP, 1'($urandom), pick_value());
        end
        // Knock on the full storage from either side, shuffle, then take some back.
        repeat ($urandom_range(3, 6))
            send_word(CMD_PUSH, 1'($urandom), pick_value());
        send_word(CMD_MOVE, 1'($urandom), pick_value());
        send_word(CMD_PUSH, 1'($urandom), pick_value());
        repeat ($urandom_range(4, 12))
            send_word(CMD_POP, 1'($urandom), pick_value());
    endtask

    // Response side: random idling, plus one long hold-off on request.
    initial
    begin
        int unsigned gap;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_active = 1'b1;
                rsp_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned push_w;
        int unsigned pop_w;
        int unsigned phase;
        logic [1:0]  op;
        sb         = new();
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = CMD_PUSH;
        stack_sel  = SEL_A;
        push_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pops, empty moves, the unused code, extreme values,
        // popping B with A loaded, and moves in both directions.
        send_word(CMD_POP, SEL_A, ALL_ZEROS);
        send_word(CMD_POP, SEL_B, ALL_ONES);
        send_word(CMD_MOVE, SEL_A, ALL_ZEROS);
        send_word(CMD_UNUSED, SEL_B, MOST_POS);
        send_word(CMD_PUSH, SEL_A, MOST_POS);
        send_word(CMD_PUSH, SEL_A, MOST_NEG);
        send_word(CMD_PUSH, SEL_B, ALL_ONES);
        send_word(CMD_PUSH, SEL_B, ALL_ZEROS);
        send_word(CMD_PUSH, SEL_B, 32'h5a5a_5a5a);
        send_word(CMD_POP, SEL_B, ALL_ZEROS);
        send_word(CMD_MOVE, SEL_A, ALL_ONES);
        send_word(CMD_POP, SEL_B, ALL_ZEROS);
        send_word(CMD_POP, SEL_A, ALL_ZEROS);
        send_word(CMD_POP, SEL_A, ALL_ZEROS);
        send_word(CMD_PUSH, SEL_B, 32'h1234_5678);
        send_word(CMD_UNUSED, SEL_A, ALL_ONES);
        send_word(CMD_MOVE, SEL_B, ALL_ZEROS);
        send_word(CMD_POP, SEL_B, ALL_ZEROS);
        send_word(CMD_POP, SEL_B, ALL_ZEROS);
        send_word(CMD_POP, SEL_B, ALL_ZEROS);
        send_word(CMD_POP, SEL_A, ALL_ZEROS);
        send_word(CMD_PUSH, SEL_A, 32'ha5a5_a5a5);
        send_word(CMD_MOVE, SEL_A, ALL_ZEROS);
        send_word(CMD_POP, SEL_A, ALL_ZEROS);
        drain_wait();

        phase = 0;
        while (real_items < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (phase == 1 || phase == 7)
            begin
                fill_stacks();
            end
            else if (phase == 3)
            begin
                // Hold the response side off while pops keep arriving, so the held
                // response word backs up into the command side.
                cmd_valid <= 1'b0;
                hold_req = 1'b1;
                while (!hold_active)
                    @(posedge clk);
                hold_req = 1'b0;
                calm = 1'b1;
                repeat (24)
                    send_word($urandom_range(0, 3) == 0 ? CMD_PUSH : CMD_POP,
                              1'($urandom), pick_value());
                calm = 1'b0;
                drain_wait();
            end
            else
            begin
                push_w = ($urandom_range(0, 1) == 1) ? 55 : 30;
                pop_w  = 85 - push_w;
                repeat ($urandom_range(40, 80))
                begin
                    r = $urandom_range(0, 99);
                    if (r < push_w)
                        op = CMD_PUSH;
                    else if (r < push_w + pop_w)
                        op = CMD_POP;
                    else if (r < 97)
                        op = CMD_MOVE;
                    else
                        op = CMD_UNUSED;
                    send_word(op, 1'($urandom), pick_value());
                end
            end
            if ($urandom_range(0, 3) == 0)
                drain_wait();
            phase++;
        end

        // A move of a full stack is the slowest thing the block does.
        calm = 1'b0;
        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
